// ----- rtl/core/hpt_pkg.sv -----
// Package for the homogeneous point transform: widths, payload structs and status codes.
// Used by every module under rtl/core; depends on nothing else.
package hpt_pkg;

	// Fraction bits of the fixed-point format and width of a coordinate.
	localparam int FRAC_BITS   = 16;
	localparam int COORD_WIDTH = 32;

	// Matrix elements are always signed 32-bit values.
	localparam int ELEM_W = 32;

	// One product of a coordinate and an element.
	localparam int PROD_W = COORD_WIDTH + ELEM_W;
	// The translation term is an element scaled by the fraction bits.
	localparam int TRAN_W = ELEM_W + FRAC_BITS;
	// A row sum of three products and the translation term, with headroom.
	localparam int SUM_W  = ((PROD_W > TRAN_W) ? PROD_W : TRAN_W) + 2;
	// Magnitude of a row sum.
	localparam int MAG_W  = SUM_W - 1;
	// Dividend: a magnitude scaled by the fraction bits.
	localparam int NUM_W  = MAG_W + FRAC_BITS;
	// Width of the shifted-divisor compare inside the divider.
	localparam int WIDE_W = NUM_W + COORD_WIDTH;

	// Configuration port.
	localparam int NUM_REGS = 8;
	localparam int CIDX_W   = 4;

	typedef logic signed [ELEM_W-1:0]      elem_t;
	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [SUM_W-1:0]       sum_t;

	// Opcodes of an input request.
	localparam logic OP_POINT = 1'b0;
	localparam logic OP_DIR   = 1'b1;

	// Status codes of a result.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_WZERO = 2'd1;
	localparam logic [1:0] STAT_SAT   = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [31:0] x_in;
		logic [31:0] y_in;
		logic [31:0] z_in;
	} in_t;

	typedef struct packed {
		logic [31:0] x_out;
		logic [31:0] y_out;
		logic [31:0] z_out;
		logic [1:0]  status;
	} out_t;

endpackage

// ----- rtl/core/hpt_dot.sv -----
// One matrix row: three multiplies in the first stage, the row sum in the second.
// Depends on hpt_pkg.
module hpt_dot (
	input  logic           clk,
	input  logic           en,
	input  hpt_pkg::coord_t x,
	input  hpt_pkg::coord_t y,
	input  hpt_pkg::coord_t z,
	input  hpt_pkg::elem_t  m0,
	input  hpt_pkg::elem_t  m1,
	input  hpt_pkg::elem_t  m2,
	input  hpt_pkg::elem_t  m3,
	input  logic           point,
	output hpt_pkg::sum_t   sum
);
	import hpt_pkg::*;

	logic signed [PROD_W-1:0] p0_s1, p1_s1, p2_s1;
	sum_t                     t_s1;
	sum_t                     sum_s2;

	// Stage 1: products and the translation term (zero for a direction).
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= PROD_W'(x) * PROD_W'(m0);
			p1_s1 <= PROD_W'(y) * PROD_W'(m1);
			p2_s1 <= PROD_W'(z) * PROD_W'(m2);
			t_s1  <= point ? (SUM_W'(m3) <<< FRAC_BITS) : '0;
		end
	end

	// Stage 2: exact row sum.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= SUM_W'(p0_s1) + SUM_W'(p1_s1) + SUM_W'(p2_s1) + t_s1;
		end
	end

	assign sum = sum_s2;

endmodule

// ----- rtl/core/hpt_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, with an overflow check up front.
// Depends on hpt_pkg.
module hpt_divider (
	input  logic                            clk,
	input  logic                            en,
	input  logic [hpt_pkg::NUM_W-1:0]       num,
	input  logic [hpt_pkg::MAG_W-1:0]       den,
	input  logic                            neg,
	output logic [hpt_pkg::COORD_WIDTH-1:0] quot,
	output logic                            ovf,
	output logic                            neg_out
);
	import hpt_pkg::*;

	logic [NUM_W-1:0]       rem_s [0:COORD_WIDTH];
	logic [MAG_W-1:0]       d_s   [0:COORD_WIDTH];
	logic [COORD_WIDTH-1:0] q_s   [0:COORD_WIDTH];
	logic                   ov_s  [0:COORD_WIDTH];
	logic                   neg_s [0:COORD_WIDTH];

	// Entry stage: the quotient overflows the coordinate width when num >= den << COORD_WIDTH.
	// A zero divisor always reads as overflow.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			d_s[0]   <= den;
			q_s[0]   <= '0;
			ov_s[0]  <= (num >> COORD_WIDTH) >= NUM_W'(den);
			neg_s[0] <= neg;
		end
	end

	// Each stage tries the divisor shifted to one quotient bit, most significant first.
	for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_stage
		localparam int SH = COORD_WIDTH - 1 - k;
		logic [WIDE_W-1:0] dsh;
		logic [WIDE_W-1:0] rw;
		logic              ge;

		assign dsh = WIDE_W'(d_s[k]) << SH;
		assign rw  = WIDE_W'(rem_s[k]);
		assign ge  = rw >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? NUM_W'(rw - dsh) : rem_s[k];
				d_s[k+1]   <= d_s[k];
				q_s[k+1]   <= {q_s[k][COORD_WIDTH-2:0], ge};
				ov_s[k+1]  <= ov_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign quot    = q_s[COORD_WIDTH];
	assign ovf     = ov_s[COORD_WIDTH];
	assign neg_out = neg_s[COORD_WIDTH];

endmodule

// ----- rtl/core/homogeneous_point_transform.sv -----
// Top level of the homogeneous point transform: matrix registers, pipeline control, saturation.
// Depends on hpt_pkg, hpt_dot and hpt_divider.

// The block takes one request per cycle unless a waiting result is stalled. Its pipeline has
// two stages of multiply and row sum, one stage of sign and magnitude, a divider of one
// overflow stage plus one stage per quotient bit, and an output register. The depth is set
// by the restoring divider, which resolves one quotient bit per stage; a direction runs
// through the same divider by a power of two.
// The whole pipeline advances together and holds while a waiting result is stalled.
// Matrix writes take effect for requests accepted after them and are taken at any time.
module homogeneous_point_transform (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  hpt_pkg::in_t                 in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output hpt_pkg::out_t                out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hpt_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [63:0]                  cfg_data
);
	import hpt_pkg::*;

	localparam int DIV_D = COORD_WIDTH + 1;

	logic [63:0] mreg_q [0:NUM_REGS-1];

	logic en;
	logic v_s1, v_s2, v_s3;
	logic op_s1, op_s2;
	logic vdiv_s [0:DIV_D-1];
	logic wz_s   [0:DIV_D-1];
	logic wz_s3;

	coord_t x, y, z;
	logic   point_in;
	sum_t   sum [0:3];

	logic [NUM_W-1:0] num_s3 [0:2];
	logic [MAG_W-1:0] den_s3;
	logic             neg_s3 [0:2];

	logic [COORD_WIDTH-1:0] quot [0:2];
	logic                   ovf  [0:2];
	logic                   qneg [0:2];

	logic [31:0] res [0:2];
	logic        sat [0:2];

	logic out_valid_q;
	out_t out_q;

	// The pipeline moves whenever the output register is empty or being taken.
	assign en        = !out_valid_q || !out_stall;
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// Matrix registers, reset to the identity; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mreg_q[0] <= 64'd65536;
			mreg_q[1] <= 64'd0;
			mreg_q[2] <= 64'd65536 << 32;
			mreg_q[3] <= 64'd0;
			mreg_q[4] <= 64'd0;
			mreg_q[5] <= 64'd65536;
			mreg_q[6] <= 64'd0;
			mreg_q[7] <= 64'd65536 << 32;
		end else if (cfg_valid && cfg_index < CIDX_W'(NUM_REGS)) begin
			mreg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// Coordinates use only their low COORD_WIDTH bits.
	assign x        = coord_t'(in_data.x_in[COORD_WIDTH-1:0]);
	assign y        = coord_t'(in_data.y_in[COORD_WIDTH-1:0]);
	assign z        = coord_t'(in_data.z_in[COORD_WIDTH-1:0]);
	assign point_in = (in_data.opcode == OP_POINT);

	// One dot-product unit per matrix row.
	for (genvar r = 0; r < 4; r++) begin : g_row
		hpt_dot u_dot (
			.clk   (clk),
			.en    (en),
			.x     (x),
			.y     (y),
			.z     (z),
			.m0    (elem_t'(mreg_q[2*r][31:0])),
			.m1    (elem_t'(mreg_q[2*r][63:32])),
			.m2    (elem_t'(mreg_q[2*r+1][31:0])),
			.m3    (elem_t'(mreg_q[2*r+1][63:32])),
			.point (point_in),
			.sum   (sum[r])
		);
	end

	// Control that runs alongside the dot-product stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= in_data.opcode;
			op_s2 <= op_s1;
		end
	end

	// Stage 3: signs, magnitudes and divider operands. A direction divides by one in
	// fixed point, which is the shift right by the fraction bits.
	always_ff @(posedge clk) begin
		logic [MAG_W-1:0] mag;
		logic [MAG_W-1:0] mag3;
		logic             pt;
		pt   = (op_s2 == OP_POINT);
		mag3 = sum[3][SUM_W-1] ? MAG_W'(-sum[3]) : MAG_W'(sum[3]);
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				mag       = sum[r][SUM_W-1] ? MAG_W'(-sum[r]) : MAG_W'(sum[r]);
				num_s3[r] <= pt ? (NUM_W'(mag) << FRAC_BITS) : NUM_W'(mag);
				neg_s3[r] <= sum[r][SUM_W-1] ^ (pt & sum[3][SUM_W-1]);
			end
			den_s3 <= pt ? mag3 : (MAG_W'(1) << FRAC_BITS);
			wz_s3  <= pt && (sum[3] == '0);
		end
	end

	// One divider per output row.
	for (genvar r = 0; r < 3; r++) begin : g_div
		hpt_divider u_div (
			.clk     (clk),
			.en      (en),
			.num     (num_s3[r]),
			.den     (den_s3),
			.neg     (neg_s3[r]),
			.quot    (quot[r]),
			.ovf     (ovf[r]),
			.neg_out (qneg[r])
		);
	end

	// Valid and zero-w flags that travel with the divider stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_D; k++) begin
				vdiv_s[k] <= 1'b0;
			end
		end else if (en) begin
			vdiv_s[0] <= v_s3;
			for (int k = 1; k < DIV_D; k++) begin
				vdiv_s[k] <= vdiv_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wz_s[0] <= wz_s3;
			for (int k = 1; k < DIV_D; k++) begin
				wz_s[k] <= wz_s[k-1];
			end
		end
	end

	// Apply the sign and saturate to the signed coordinate range.
	always_comb begin
		logic signed [COORD_WIDTH-1:0] v;
		logic                          big;
		v   = '0;
		big = 1'b0;
		for (int r = 0; r < 3; r++) begin
			if (qneg[r]) begin
				big = quot[r][COORD_WIDTH-1] && (|quot[r][COORD_WIDTH-2:0]);
			end else begin
				big = quot[r][COORD_WIDTH-1];
			end
			sat[r] = ovf[r] || big;
			if (sat[r]) begin
				v = qneg[r] ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
			end else begin
				v = qneg[r] ? COORD_WIDTH'(-quot[r]) : quot[r];
			end
			res[r] = 32'(v);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vdiv_s[DIV_D-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.x_out <= res[0];
			out_q.y_out <= res[1];
			out_q.z_out <= res[2];
			if (wz_s[DIV_D-1]) begin
				out_q.status <= STAT_WZERO;
			end else if (sat[0] || sat[1] || sat[2]) begin
				out_q.status <= STAT_SAT;
			end else begin
				out_q.status <= STAT_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A result never carries the unused status code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status != 2'd3))
		else $error("unused status code on a result");

	// A zero divisor gives saturated coordinates; this check looks at x.
	a_wzero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == STAT_WZERO) |->
		((out_data.x_out == 32'(signed'({1'b0, {(COORD_WIDTH-1){1'b1}}})) ||
		  out_data.x_out == 32'(signed'({1'b1, {(COORD_WIDTH-1){1'b0}}})))))
		else $error("zero w result is not saturated");

	// No request enters while a finished result waits.
	a_hold_in: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("request accepted while the output is stalled");

	// A held result stays valid in the next cycle.
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

endmodule

// ----- tb/homogeneous_point_transform_test.sv -----
// Testbench for homogeneous_point_transform: directed and random vertex streams under
// several matrix settings, each result checked against a built-in fixed-point predictor.
// Depends on hpt_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module homogeneous_point_transform_test;
	import hpt_pkg::*;

	localparam int           TIMEOUT_CYCLES = 400000;
	localparam int           DRAIN_CYCLES   = 50;
	localparam logic [31:0]  Q_ONE          = 32'h0001_0000;
	localparam logic [31:0]  Q_MAX          = 32'h7fff_ffff;
	localparam logic [31:0]  Q_MIN          = 32'h8000_0000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_t        out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// Matrix copy held by the predictor, and the results still owed by the block.
	logic [63:0] matrix_regs [NUM_REGS];
	out_t        pending_results [$];
	int          mismatches = 0;
	int          cycle_count = 0;
	bit          quiet = 1'b0;
	int          stall_left = 0;

	// Handshake flags sampled at the falling edge, where every signal is settled.
	logic        in_taken, out_taken, cfg_taken;
	out_t        out_seen;

	homogeneous_point_transform u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		in_taken  = in_valid && !in_stall;
		out_taken = out_valid && !out_stall;
		cfg_taken = cfg_valid && cfg_ready;
		out_seen  = out_data;
	end

	// Global watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == TIMEOUT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result-side stall in random bursts, none once the run goes quiet.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 12);
		end
		out_stall <= (stall_left > 0);
	end

	// Matrix element (r, c) as a signed 32-bit value.
	function automatic elem_t matrix_elem(int r, int c);
		logic [63:0] reg_val;
		reg_val = matrix_regs[2 * r + c / 2];
		return (c % 2) ? elem_t'(reg_val[63:32]) : elem_t'(reg_val[31:0]);
	endfunction

	// Exact row sum of (x, y, z, w) with one matrix row.
	function automatic logic signed [127:0] row_dot(int r, logic signed [127:0] x,
			logic signed [127:0] y, logic signed [127:0] z, bit with_w);
		logic signed [127:0] e0, e1, e2, e3, acc;
		e0 = matrix_elem(r, 0);
		e1 = matrix_elem(r, 1);
		e2 = matrix_elem(r, 2);
		e3 = matrix_elem(r, 3);
		acc = x * e0 + y * e1 + z * e2;
		if (with_w)
			acc = acc + (e3 <<< FRAC_BITS);
		return acc;
	endfunction

	function automatic logic [127:0] magnitude(logic signed [127:0] v);
		return (v < 0) ? -v : v;
	endfunction

	// Apply a sign to a magnitude and clamp to the signed 32-bit range.
	function automatic logic [31:0] clamp_coord(bit neg, logic [127:0] mag, inout bit sat);
		logic [127:0] limit;
		limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (mag > limit) begin
			sat = 1'b1;
			return neg ? Q_MIN : Q_MAX;
		end
		return neg ? -mag[31:0] : mag[31:0];
	endfunction

	// Expected result of one vertex under the current matrix.
	function automatic out_t transform_vertex(in_t req);
		logic signed [127:0] x, y, z, den, num;
		logic [31:0] coords [3];
		bit sat, wzero;
		out_t res;
		x = coord_t'(req.x_in);
		y = coord_t'(req.y_in);
		z = coord_t'(req.z_in);
		sat = 1'b0;
		wzero = 1'b0;
		den = row_dot(3, x, y, z, 1'b1);
		for (int r = 0; r < 3; r++) begin
			if (req.opcode == OP_DIR) begin
				num = row_dot(r, x, y, z, 1'b0);
				coords[r] = clamp_coord(num < 0, magnitude(num) >> FRAC_BITS, sat);
			end else begin
				num = row_dot(r, x, y, z, 1'b1);
				if (den == 0) begin
					wzero = 1'b1;
					coords[r] = (num < 0) ? Q_MIN : Q_MAX;
				end else begin
					coords[r] = clamp_coord((num < 0) != (den < 0),
						(magnitude(num) << FRAC_BITS) / magnitude(den), sat);
				end
			end
		end
		res.x_out = coords[0];
		res.y_out = coords[1];
		res.z_out = coords[2];
		res.status = wzero ? STAT_WZERO : (sat ? STAT_SAT : STAT_OK);
		return res;
	endfunction

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		out_t want;
		if (out_taken) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", out_seen);
			end else begin
				want = pending_results.pop_front();
				if (want.x_out !== out_seen.x_out || want.y_out !== out_seen.y_out ||
						want.z_out !== out_seen.z_out || want.status !== out_seen.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected x %h y %h z %h st %0d, got x %h y %h z %h st %0d",
							want.x_out, want.y_out, want.z_out, want.status,
							out_seen.x_out, out_seen.y_out, out_seen.z_out, out_seen.status);
				end
			end
		end
	end

	// Send one vertex request, record its expected result, then maybe idle.
	task automatic send_vertex(logic opcode, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		in_t req;
		int gap;
		req.opcode = opcode;
		req.x_in = x;
		req.y_in = y;
		req.z_in = z;
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_taken);
		pending_results = {pending_results, transform_vertex(req)};
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait until every result is back and the pipeline has emptied.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; cfg_valid is dropped again before the task returns.
	task automatic write_reg(int index, logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index[CIDX_W-1:0];
		cfg_data <= value;
		do @(posedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
		if (index < NUM_REGS)
			matrix_regs[index] = value;
		@(posedge clk);
	endtask

	// Load a whole matrix given row by row.
	task automatic load_matrix(logic [31:0] m [4][4]);
		for (int r = 0; r < 4; r++) begin
			write_reg(2 * r, {m[r][1], m[r][0]});
			write_reg(2 * r + 1, {m[r][3], m[r][2]});
		end
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return ($urandom_range(0, 1)) ? Q_MAX : Q_MIN;
			2: return 32'($signed($urandom_range(0, 8)) - 4);
			default: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_small_elem(int range_q);
		return 32'($signed($urandom_range(0, 2 * range_q)) - range_q);
	endfunction

	// Reset matrix is the identity: points and directions pass through.
	task automatic test_identity_reset();
		send_vertex(OP_POINT, Q_ONE, 32'h0002_8000, 32'hfffd_0000);
		send_vertex(OP_DIR, Q_ONE, 32'h0002_8000, 32'hfffd_0000);
		send_vertex(OP_POINT, Q_MAX, Q_MIN, 32'h0);
		send_vertex(OP_DIR, Q_MIN, Q_MAX, 32'hffff_ffff);
		send_vertex(OP_POINT, 32'h0, 32'h0, 32'h0);
		wait_idle();
	endtask

	// Registers past the end of the list are ignored; extreme element values.
	task automatic test_register_extremes();
		logic [31:0] m [4][4];
		for (int i = NUM_REGS; i < (1 << CIDX_W); i++)
			write_reg(i, {$urandom(), $urandom()});
		send_vertex(OP_POINT, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000);
		wait_idle();
		foreach (m[r, c]) m[r][c] = Q_MIN;
		load_matrix(m);
		send_vertex(OP_POINT, Q_MIN, Q_MIN, Q_MIN);
		send_vertex(OP_DIR, Q_MIN, Q_MIN, Q_MIN);
		send_vertex(OP_POINT, Q_MAX, 32'h1, Q_MIN);
		wait_idle();
		foreach (m[r, c]) m[r][c] = Q_MAX;
		load_matrix(m);
		send_vertex(OP_POINT, Q_MAX, Q_MAX, Q_MAX);
		send_vertex(OP_DIR, Q_MAX, Q_MIN, Q_MAX);
		send_vertex(OP_POINT, 32'h1, 32'h0, 32'h0);
		wait_idle();
	endtask

	// Zero divisor: outputs go to the rail picked by each numerator's sign.
	task automatic test_zero_w();
		logic [31:0] m [4][4];
		foreach (m[r, c]) m[r][c] = '0;
		m[0][3] = 32'hfff0_0000;
		m[1][3] = 32'h0;
		m[2][0] = Q_ONE;
		m[2][1] = Q_MAX;
		load_matrix(m);
		send_vertex(OP_POINT, 32'h0001_0000, 32'h0, 32'h0);
		send_vertex(OP_POINT, 32'hffff_0000, 32'h0, 32'h0);
		send_vertex(OP_DIR, 32'h0001_0000, 32'h0004_0000, 32'h0);
		wait_idle();
		// A perspective row whose dot product cancels to zero.
		m[3][0] = Q_ONE;
		m[3][3] = Q_ONE;
		load_matrix(m);
		send_vertex(OP_POINT, 32'hffff_0000, 32'h0001_0000, 32'h0);
		send_vertex(OP_POINT, 32'hffff_0000, 32'h7fff_0000, 32'h0);
		wait_idle();
	endtask

	// Projective matrix with small divisors to force saturation.
	task automatic test_saturation();
		logic [31:0] m [4][4];
		foreach (m[r, c]) m[r][c] = (r == c) ? Q_ONE : 32'h0;
		m[3][3] = 32'h0000_0001;
		m[0][3] = 32'h0100_0000;
		load_matrix(m);
		send_vertex(OP_POINT, 32'h0001_0000, 32'hffff_0000, 32'h0);
		send_vertex(OP_POINT, 32'h0, 32'h0, 32'h0);
		send_vertex(OP_DIR, Q_MAX, Q_MIN, 32'h0);
		wait_idle();
	endtask

	// Random matrices of several kinds, each followed by a random vertex stream.
	task automatic test_random_streams(int phases, int items_per_phase);
		logic [31:0] m [4][4];
		for (int p = 0; p < phases; p++) begin
			foreach (m[r, c]) begin
				case (p % 4)
					0: m[r][c] = (c == 3) ? rand_small_elem(32'h03e8_0000) : rand_small_elem(32'h0004_0000);
					1: m[r][c] = rand_small_elem(32'h0002_0000);
					2: m[r][c] = $urandom();
					default: m[r][c] = (r == 3) ? 32'h0 : rand_small_elem(32'h0008_0000);
				endcase
			end
			if (p % 4 == 0) begin
				m[3][0] = '0; m[3][1] = '0; m[3][2] = '0; m[3][3] = Q_ONE;
			end
			load_matrix(m);
			for (int i = 0; i < items_per_phase; i++)
				send_vertex(logic'($urandom_range(0, 3) == 0), rand_coord(), rand_coord(),
					rand_coord());
			wait_idle();
		end
	endtask

	initial begin
		matrix_regs[0] = 64'd65536;
		matrix_regs[1] = 64'd0;
		matrix_regs[2] = 64'd65536 << 32;
		matrix_regs[3] = 64'd0;
		matrix_regs[4] = 64'd0;
		matrix_regs[5] = 64'd65536;
		matrix_regs[6] = 64'd0;
		matrix_regs[7] = 64'd65536 << 32;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity_reset();
		test_register_extremes();
		test_zero_w();
		test_saturation();
		test_random_streams(10, 100);
		quiet = 1'b1;
		test_random_streams(2, 75);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
